// ===== rtl/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants of the ultrasonic ranging sequencer
// Beat payload structs, configuration set, phase encoding, register indexes.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int unsigned ECHO_W   = 2;
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd2;

  localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS  = 8'd20;
  localparam logic [TMO_W-1:0]   RST_TIMEOUT_TICKS  = 16'd50000;
  localparam logic [SCALE_W-1:0] RST_DISTANCE_SCALE = 8'd17;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  typedef struct packed {
    logic              start_req;
    logic [ECHO_W-1:0] echo_level;
  } in_t;

  typedef struct packed {
    logic [ECHO_W-1:0] trigger_level;
    logic              busy_res;
    logic              result_valid;
    logic              result_sensor;
    logic [DIST_W-1:0] result_distance;
    logic              result_no_echo;
  } out_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [TMO_W-1:0]   timeout_ticks;
    logic [SCALE_W-1:0] distance_scale;
  } cfg_t;

endpackage

// ===== rtl/ultrasonic_ranging_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranging_sequencer_top: ultrasonic echo ranging sequencer
// Each input beat is one 1 us tick carrying a start request and the echo
// levels; each accepted beat yields exactly one result beat with trigger
// levels, busy flag and, when a sensor finishes, its distance or no-echo.
//
// Channels: in_* (valid/stall) carries ticks, out_* (valid/stall) carries
// results, cfg_* writes trigger_ticks (0), timeout_ticks (1), distance_scale
// (2); the user must write only while idle: the block does not enforce it.
// Output: the result of a tick appears on out_* in the cycle after it is
// accepted. Throughput: one tick per cycle while out_* is not stalled, set by
// the state update feeding the output register.
// Stall: the output register holds its beat while out_stall is high; the
// next tick is still taken in the cycle the held beat drains, and in_stall
// is high only while a held beat sits stalled.
// Reset (rst_n low, synchronous): phase idle, sensor 0, counter zero,
// registers at 20 / 50000 / 17, output empty.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer_top #(
  parameter int NUM_SENSORS = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  urs_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output urs_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [urs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import urs_pkg::*;

  cfg_t cfg;
  out_t res;
  out_t out_data_r;
  logic out_valid_r;
  logic accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  urs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urs_fsm #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .in_beat (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/urs_cfg.sv =====
// ----------------------------------------------------------------------------
// urs_cfg: configuration register file
// Holds trigger length, echo timeout and distance scale; write-only port.
// ----------------------------------------------------------------------------
module urs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [urs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output urs_pkg::cfg_t                     cfg
);
  import urs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks  <= RST_TRIGGER_TICKS;
      cfg_r.timeout_ticks  <= RST_TIMEOUT_TICKS;
      cfg_r.distance_scale <= RST_DISTANCE_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS:  cfg_r.trigger_ticks  <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= cfg_data[TMO_W-1:0];
        REG_DISTANCE_SCALE: cfg_r.distance_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/urs_fsm.sv =====
// ----------------------------------------------------------------------------
// urs_fsm: ranging sequencer state machine
// Advances phase, sensor index and tick counter once per accepted beat and
// forms that beat's result.
// ----------------------------------------------------------------------------
module urs_fsm #(
  parameter int NUM_SENSORS = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  urs_pkg::in_t  in_beat,
  input  urs_pkg::cfg_t cfg,
  output urs_pkg::out_t res
);
  import urs_pkg::*;

  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(NUM_SENSORS - 1);

  phase_t            phase_r, phase_nxt;
  logic [SIDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cnt_inc;
  logic              echo;
  logic              fin;
  logic              fin_no_echo;
  logic [DIST_W-1:0] prod;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign echo    = ({1'b0, idx_r} < (SIDX_W+1)'(ECHO_W)) ? in_beat.echo_level[idx_r[0]]
                                                         : 1'b0;
  assign prod    = DIST_W'(cnt_r) * DIST_W'(cfg.distance_scale);

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    fin         = 1'b0;
    fin_no_echo = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (in_beat.start_req) begin
          phase_nxt = PH_TRIG;
          idx_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      PH_TRIG: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(cfg.trigger_ticks)) begin
          phase_nxt = PH_RISE;
          cnt_nxt   = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          phase_nxt = PH_FALL;
          cnt_nxt   = CNT_W'(1);
          if (CNT_W'(1) >= cfg.timeout_ticks) begin
            fin         = 1'b1;
            fin_no_echo = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= cfg.timeout_ticks) begin
            fin         = 1'b1;
            fin_no_echo = 1'b1;
          end
        end
      end
      PH_FALL: begin
        if (!echo) begin
          fin = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= cfg.timeout_ticks) begin
            fin         = 1'b1;
            fin_no_echo = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        idx_nxt   = '0;
        cnt_nxt   = '0;
      end
    endcase
    if (fin) begin
      cnt_nxt = '0;
      if (idx_r == LAST_IDX) begin
        idx_nxt   = '0;
        phase_nxt = PH_IDLE;
      end else begin
        idx_nxt   = idx_r + SIDX_W'(1);
        phase_nxt = PH_TRIG;
      end
    end
  end

  always_comb begin
    res = '0;
    if (phase_nxt == PH_TRIG && {1'b0, idx_nxt} < (SIDX_W+1)'(ECHO_W)) begin
      res.trigger_level = ECHO_W'(1) << idx_nxt[0];
    end
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.result_valid = fin;
    if (fin) begin
      res.result_sensor  = idx_r[0];
      res.result_no_echo = fin_no_echo;
      if (!fin_no_echo) begin
        res.result_distance = prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== verif/ultrasonic_ranging_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranging_sequencer_top_tb: tick-level check of the ranging sequencer
// Ticks go in from a queue with random send gaps. Results are taken with
// random stalls. Each accepted tick steps an in-bench copy of the sequencer;
// the result it gives is compared field by field with the beat that comes out.
// Timings are changed between runs while nothing is in flight. The stimulus is
// mostly full ranging passes with echo pulses and timeouts, plus some noise.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_sequencer_top_tb;
  import urs_pkg::*;

  localparam int SENSORS = 2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ultrasonic_ranging_sequencer_top #(.NUM_SENSORS(SENSORS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // timing registers as the block should hold them
  logic [TRIG_W-1:0]  trig_len   = RST_TRIGGER_TICKS;
  logic [TMO_W-1:0]   echo_limit = RST_TIMEOUT_TICKS;
  logic [SCALE_W-1:0] dist_scale = RST_DISTANCE_SCALE;

  // sequencer state
  phase_t           seq_phase  = PH_IDLE;
  int unsigned      seq_sensor = 0;
  logic [CNT_W-1:0] seq_count  = '0;

  in_t  tick_queue[$];
  out_t pending_reports[$];
  int   planned_ticks = 0;
  int   mismatches = 0;
  int   send_odds = 0;
  int   recv_odds = 0;
  int   send_wait = 0;
  int   recv_hold = 0;

  function automatic out_t close_sensor(out_t r, logic [DIST_W-1:0] span, logic miss);
    r.result_valid    = 1'b1;
    r.result_sensor   = seq_sensor[0];
    r.result_distance = span;
    r.result_no_echo  = miss;
    seq_count = '0;
    if (seq_sensor + 1 < SENSORS) begin
      seq_sensor++;
      seq_phase = PH_TRIG;
    end else begin
      seq_sensor = 0;
      seq_phase = PH_IDLE;
    end
    return r;
  endfunction

  function automatic out_t advance_sequencer(in_t tick);
    out_t r;
    logic echo;
    r = '0;
    echo = (seq_sensor < ECHO_W) ? tick.echo_level[seq_sensor[0]] : 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (tick.start_req) begin
          seq_phase = PH_TRIG;
          seq_sensor = 0;
          seq_count = '0;
        end
      end
      PH_TRIG: begin
        seq_count = seq_count + CNT_W'(1);
        if (seq_count >= CNT_W'(trig_len)) begin
          seq_phase = PH_RISE;
          seq_count = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          seq_phase = PH_FALL;
          seq_count = CNT_W'(1);
        end else begin
          seq_count = seq_count + CNT_W'(1);
        end
        if (seq_count >= echo_limit) r = close_sensor(r, '0, 1'b1);
      end
      PH_FALL: begin
        if (!echo) begin
          r = close_sensor(r, DIST_W'(seq_count) * DIST_W'(dist_scale), 1'b0);
        end else begin
          seq_count = seq_count + CNT_W'(1);
          if (seq_count >= echo_limit) r = close_sensor(r, '0, 1'b1);
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_sensor = 0;
        seq_count = '0;
      end
    endcase
    if (seq_phase == PH_TRIG && seq_sensor < ECHO_W) r.trigger_level[seq_sensor[0]] = 1'b1;
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  function automatic int draw_wait(int odds);
    if (odds == 0) return 0;
    return ($urandom_range(0, odds - 1) == 0) ? $urandom_range(0, 18) : 0;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        pending_reports.push_back(advance_sequencer(in_data));
        send_wait = draw_wait(send_odds);
      end
      if (send_wait == 0 && tick_queue.size() > 0) begin
        in_data  <= tick_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (send_wait > 0) send_wait--;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          note_mismatch("result beat with nothing pending", '0, 32'(out_data));
        end else begin
          want = pending_reports.pop_front();
          if (out_data.trigger_level !== want.trigger_level)
            note_mismatch("trigger_level", 32'(want.trigger_level),
                          32'(out_data.trigger_level));
          if (out_data.busy_res !== want.busy_res)
            note_mismatch("busy_res", 32'(want.busy_res), 32'(out_data.busy_res));
          if (out_data.result_valid !== want.result_valid)
            note_mismatch("result_valid", 32'(want.result_valid),
                          32'(out_data.result_valid));
          if (out_data.result_sensor !== want.result_sensor)
            note_mismatch("result_sensor", 32'(want.result_sensor),
                          32'(out_data.result_sensor));
          if (out_data.result_distance !== want.result_distance)
            note_mismatch("result_distance", 32'(want.result_distance),
                          32'(out_data.result_distance));
          if (out_data.result_no_echo !== want.result_no_echo)
            note_mismatch("result_no_echo", 32'(want.result_no_echo),
                          32'(out_data.result_no_echo));
        end
        recv_hold = draw_wait(recv_odds);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  task automatic put_tick(logic start, logic [ECHO_W-1:0] echo);
    in_t t;
    t.start_req  = start;
    t.echo_level = echo;
    tick_queue.push_back(t);
    planned_ticks++;
  endtask

  task automatic put_echo(int s, logic level, int unsigned n);
    logic [ECHO_W-1:0] e;
    repeat (n) begin
      e = ECHO_W'($urandom);
      if (s < ECHO_W) e[s[0]] = level;
      put_tick(1'($urandom), e);
    end
  endtask

  // one full pass: start, then per sensor a trigger, an echo pulse or a timeout
  task automatic queue_pass(int unsigned cap);
    int unsigned lim;
    int unsigned roll;
    put_tick(1'b1, ECHO_W'($urandom));
    for (int s = 0; s < SENSORS; s++) begin
      repeat (trig_len) put_tick(1'($urandom), ECHO_W'($urandom));
      lim = (echo_limit - 1 < cap) ? echo_limit - 1 : cap;
      roll = $urandom_range(0, 9);
      if (echo_limit > 1 && (roll < 8 || echo_limit > cap)) begin
        put_echo(s, 1'b0, $urandom_range(0, lim));
        put_echo(s, 1'b1, $urandom_range(1, lim));
        put_echo(s, 1'b0, 1);
      end else if (roll[0]) begin
        put_echo(s, 1'b0, 32'(echo_limit));
      end else begin
        put_echo(s, 1'b0, $urandom_range(0, lim));
        put_echo(s, 1'b1, 32'(echo_limit));
      end
    end
    repeat ($urandom_range(0, 3)) put_tick(1'b0, ECHO_W'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TRIGGER_TICKS:  trig_len = val[TRIG_W-1:0];
      REG_TIMEOUT_TICKS:  echo_limit = val[TMO_W-1:0];
      REG_DISTANCE_SCALE: dist_scale = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [TRIG_W-1:0] t, logic [TMO_W-1:0] m,
                                logic [SCALE_W-1:0] sc, bit junk);
    logic [7:0] pad;
    pad = junk ? 8'($urandom) : 8'h00;
    write_reg(REG_TRIGGER_TICKS, {pad, t});
    write_reg(REG_TIMEOUT_TICKS, m);
    write_reg(REG_DISTANCE_SCALE, {~pad, sc});
    if (junk) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    send_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    recv_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || pending_reports.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [TRIG_W-1:0]  t;
    logic [TMO_W-1:0]   m;
    logic [SCALE_W-1:0] sc;
    bit noisy;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset timings
    send_odds = 3;
    recv_odds = 3;
    repeat (2) queue_pass(20);
    drain();

    // directed: echo widths of one, rise and fall timeouts, starts while busy
    apply_settings(8'd1, 16'd2, 8'd255, 1'b1);
    put_tick(1'b0, 2'b11);
    put_tick(1'b1, 2'b00);
    put_tick(1'b0, 2'b00);
    put_tick(1'b0, 2'b01);
    put_tick(1'b0, 2'b00);
    put_tick(1'b1, 2'b10);
    put_tick(1'b0, 2'b00);
    put_tick(1'b0, 2'b01);
    put_tick(1'b1, 2'b11);
    put_tick(1'b0, 2'b11);
    put_tick(1'b0, 2'b11);
    put_tick(1'b0, 2'b11);
    put_tick(1'b0, 2'b00);
    put_tick(1'b0, 2'b10);
    put_tick(1'b1, 2'b01);
    put_tick(1'b1, 2'b01);
    put_tick(1'b0, 2'b00);
    put_tick(1'b0, 2'b00);
    put_tick(1'b0, 2'b01);
    put_tick(1'b0, 2'b00);
    put_tick(1'b1, 2'b11);
    put_tick(1'b1, 2'b10);
    put_tick(1'b0, 2'b00);
    drain();

    // shortest timings: every wait ends on its first tick
    apply_settings(8'd1, 16'd1, 8'd1, 1'b0);
    repeat (6) queue_pass(20);
    drain();

    // longest timings
    apply_settings(8'd255, 16'd65535, 8'd255, 1'b1);
    queue_pass(30);
    drain();

    while (planned_ticks < 1700) begin
      t  = ($urandom_range(0, 9) == 0) ? TRIG_W'($urandom_range(9, 60))
                                       : TRIG_W'($urandom_range(1, 8));
      m  = ($urandom_range(0, 5) == 0) ? TMO_W'($urandom_range(41, 65535))
                                       : TMO_W'($urandom_range(1, 40));
      sc = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd1)
                                       : SCALE_W'($urandom_range(1, 255));
      apply_settings(t, m, sc, 1'($urandom));
      noisy = 1'b0;
      repeat ($urandom_range(3, 8)) begin
        if (echo_limit <= 40 && $urandom_range(0, 6) == 0) begin
          noisy = 1'b1;
          repeat ($urandom_range(1, 10)) put_tick(($urandom_range(0, 3) == 0), ECHO_W'($urandom));
        end else begin
          queue_pass(20);
        end
      end
      // quiet ticks time out whatever pass the noise left open
      if (noisy) repeat (SENSORS * (trig_len + echo_limit + 1) + 1) put_tick(1'b0, '0);
      drain();
    end

    drain();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/urs_pkg.sv
rtl/urs_cfg.sv
rtl/urs_fsm.sv
rtl/ultrasonic_ranging_sequencer_top.sv
verif/ultrasonic_ranging_sequencer_top_tb.sv
